>>> rtl/core/vtsed_pkg.sv
// Package for the single-error decoder: field widths, status codes, FSM type.
// No dependencies.
package vtsed_pkg;
    localparam int RX_W  = 33;
    localparam int LEN_W = 6;
    localparam int OUT_W = 32;
    localparam int ST_W  = 3;
    localparam int MOD_W = 7;

    localparam logic [ST_W-1:0] ST_VALID = 3'd0;
    localparam logic [ST_W-1:0] ST_SUBST = 3'd1;
    localparam logic [ST_W-1:0] ST_DEL   = 3'd2;
    localparam logic [ST_W-1:0] ST_INS   = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_EVAL,
        S_DELS,
        S_INSS,
        S_OUT
    } t_state;
endpackage

>>> rtl/core/vtsed_ifs.sv
// Valid/ready channel interfaces for received words, decoded words and config.
// Depends on vtsed_pkg.
interface vtsed_in_if import vtsed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RX_W-1:0]  received_bits;
    logic [LEN_W-1:0] received_len;
    modport source (output valid, received_bits, received_len, input ready);
    modport sink   (input valid, received_bits, received_len, output ready);
endinterface

interface vtsed_out_if import vtsed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] corrected_bits;
    logic [ST_W-1:0]  status;
    modport source (output valid, corrected_bits, status, input ready);
    modport sink   (input valid, corrected_bits, status, output ready);
endinterface

interface vtsed_cfg_if import vtsed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/vt_single_error_decoder.sv
// Top level of the single-error decoder: bit-serial sum scan and repair search.
// Depends on vtsed_pkg and vtsed_ifs.
//
//  channel  dir  modport  word
//  i_in     in   sink     received_bits, received_len
//  o_out    out  source   corrected_bits, status
//  i_cfg    in   sink     code_length
//
// A valid, substitution or bad word needs only the sum scan; a deletion or
// insertion may add a position search. One shared add/compare-subtract unit
// walks the word a bit per cycle, first for the weighted sum, then for an
// insertion's position. i_in is ready only in idle; the result is held
// until taken. Reset is synchronous active low and sets code_length to 32.
module vt_single_error_decoder
    import vtsed_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vtsed_in_if.sink   i_in,
    vtsed_out_if.source o_out,
    vtsed_cfg_if.sink  i_cfg
);
    localparam int WW = MAX_LEN + 1;
    localparam int IW = $clog2(WW);

    t_state r_state, n_state;

    logic [LEN_W-1:0] r_n;
    logic [WW-1:0]    r_w;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_p;
    logic [MOD_W-1:0] r_s;
    logic [MOD_W-1:0] r_wt;
    logic [MOD_W-1:0] r_cnt;
    logic [MOD_W-1:0] r_d;
    logic             r_zero_ins;
    logic [WW-1:0]    r_res;
    logic [ST_W-1:0]  r_st;

    logic [MOD_W-1:0] m;
    logic             code_ok;
    logic             len_sub, len_del, len_ins;
    logic             bit_p, bit_pm1;
    logic             sum_done, del_cont, ins_hit, ins_last;
    logic [MOD_W:0]   acc;
    logic [MOD_W-1:0] acc_red;
    logic [MOD_W-1:0] above;
    logic [MOD_W-1:0] seen_pos;
    logic [63:0]      rx64, res64;
    logic [WW-1:0]    w_in;

    function automatic logic [WW-1:0] f_insert(logic [WW-1:0] w, logic [LEN_W-1:0] i,
                                               logic b);
        logic [WW-1:0] sh;
        logic [WW-1:0] res;
        sh = {w[WW-2:0], 1'b0};
        for (int k = 0; k < WW; k++) begin
            if (k < 32'(i)) res[k] = w[k];
            else if (k == 32'(i)) res[k] = b;
            else res[k] = sh[k];
        end
        return res;
    endfunction

    function automatic logic [WW-1:0] f_remove(logic [WW-1:0] w, logic [LEN_W-1:0] j);
        logic [WW-1:0] sh;
        logic [WW-1:0] res;
        sh = {1'b0, w[WW-1:1]};
        for (int k = 0; k < WW; k++) begin
            if (k < 32'(j)) res[k] = w[k];
            else res[k] = sh[k];
        end
        return res;
    endfunction

    assign m       = {1'b0, r_n} + 7'd1;
    assign code_ok = (r_n >= 6'd2) && ({1'b0, r_n} <= MOD_W'(MAX_LEN));
    assign len_sub = (r_len == r_n);
    assign len_del = ({1'b0, r_len} + 7'd1 == {1'b0, r_n});
    assign len_ins = ({1'b0, r_len} == m);

    assign rx64 = 64'(i_in.received_bits);
    always_comb begin
        for (int k = 0; k < WW; k++) begin
            w_in[k] = (k < 32'(i_in.received_len)) ? rx64[k] : 1'b0;
        end
    end

    assign bit_p    = r_w[r_p[IW-1:0]];
    assign bit_pm1  = r_w[IW'(r_p - 6'd1)];
    assign sum_done = (r_p == r_len);

    // shared adder: sum scan adds p+1, insertion scan adds (j+1)*w[j] + ones above
    assign above = r_cnt - {6'd0, bit_p};
    always_comb begin
        if (r_state == S_INSS) acc = {1'b0, above} + (bit_p ? {2'b0, r_p} + 8'd1 : 8'd0);
        else acc = {1'b0, r_s} + {2'b0, r_p} + 8'd1;
        acc_red = (acc >= {1'b0, m}) ? MOD_W'(acc - {1'b0, m}) : acc[MOD_W-1:0];
    end

    assign seen_pos = {1'b0, r_p} + 7'd1 + r_cnt;
    assign del_cont = (r_p != '0) &&
                      (r_zero_ins ? (r_cnt != r_d) : (seen_pos != r_d));
    assign ins_hit  = (acc_red == r_s);
    assign ins_last = ({1'b0, r_p} == {1'b0, r_n});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_SUM;
            S_SUM:  if (sum_done) n_state = S_EVAL;
            S_EVAL: begin
                if (code_ok && len_del && r_s != '0) n_state = S_DELS;
                else if (code_ok && len_ins) n_state = S_INSS;
                else n_state = S_OUT;
            end
            S_DELS: if (!del_cont) n_state = S_OUT;
            S_INSS: if (ins_hit || ins_last) n_state = S_OUT;
            S_OUT:  if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        o_out.valid = (r_state == S_OUT);
        i_cfg.ready = 1'b1;
    end

    assign res64                = 64'(r_res);
    assign o_out.corrected_bits = res64[OUT_W-1:0];
    assign o_out.status         = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= 6'd32;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_n <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_w   <= w_in;
                r_len <= i_in.received_len;
                r_p   <= '0;
                r_s   <= '0;
                r_wt  <= '0;
            end
            S_SUM: begin
                if (!sum_done) begin
                    if (bit_p) begin
                        r_s  <= acc_red;
                        r_wt <= r_wt + 7'd1;
                    end
                    r_p <= r_p + 6'd1;
                end
            end
            S_EVAL: begin
                r_res <= '0;
                r_st  <= ST_BAD;
                r_cnt <= '0;
                r_p   <= r_len;
                r_d   <= m - r_s;
                r_zero_ins <= ((m - r_s) <= r_wt);
                if (code_ok && len_sub) begin
                    if (r_s == '0) begin
                        r_res <= r_w;
                        r_st  <= ST_VALID;
                    end else begin
                        r_res <= r_w & ~(WW'(1) << IW'(r_s - 7'd1));
                        r_st  <= ST_SUBST;
                    end
                end else if (code_ok && len_del) begin
                    r_res <= r_w;
                    r_st  <= ST_DEL;
                end else if (code_ok && len_ins) begin
                    r_p   <= '0;
                    r_cnt <= r_wt;
                end
            end
            S_DELS: begin
                if (del_cont) begin
                    r_p   <= r_p - 6'd1;
                    r_cnt <= r_cnt + {6'd0, bit_pm1};
                end else begin
                    r_res <= f_insert(r_w, r_p, !r_zero_ins);
                end
            end
            S_INSS: begin
                if (ins_hit) begin
                    r_res <= f_remove(r_w, r_p);
                    r_st  <= ST_INS;
                end else begin
                    r_p   <= r_p + 6'd1;
                    r_cnt <= above;
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end
endmodule
